[sv/fbpa_pkg.sv]
// Shared types and constants for the fixed block pool allocator.
`default_nettype none

package fbpa_pkg;

	localparam int MAX_BLOCKS = 32;
	localparam int IDX_W      = 5;
	localparam int CNT_W      = 6;
	localparam int ADDR_W     = 32;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_FULL         = 2'd1,
		ST_OUTSIDE      = 2'd2,
		ST_ALREADY_FREE = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    take_bit;
		logic    give_bit;
		logic    load_idx;
		logic    post;
		logic    post_addr;
		status_t post_status;
	} fbpa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic in_range;
		logic past_managed;
		logic bit_free;
		logic res_busy;
	} fbpa_stat_t;

endpackage

`default_nettype wire

[sv/fbpa_req_if.sv]
// Request channel: valid, ready and the request payload.
`default_nettype none

interface fbpa_req_if;

	logic        valid;
	logic        ready;
	logic        mode;
	logic [31:0] free_address;

	modport source (output valid, output mode, output free_address, input ready);
	modport sink (input valid, input mode, input free_address, output ready);

endinterface

`default_nettype wire

[sv/fbpa_rsp_if.sv]
// Response channel: valid, ready and the result payload.
`default_nettype none

interface fbpa_rsp_if;

	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] block_address;
	logic [5:0]  blocks_in_use;

	modport source (output valid, output status, output block_address,
		output blocks_in_use, input ready);
	modport sink (input valid, input status, input block_address,
		input blocks_in_use, output ready);

endinterface

`default_nettype wire

[sv/fbpa_datapath.sv]
// Datapath of the allocator: free map, use count, address math and result register.
`default_nettype none

module fbpa_datapath import fbpa_pkg::*; #(
	parameter int POOL_BYTES  = 1024,
	parameter int BLOCK_BYTES = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [ADDR_W-1:0] cfg_wdata,
	input  wire logic [ADDR_W-1:0] req_free_address,
	input  wire fbpa_cmd_t         cmd,
	output fbpa_stat_t             stat,
	fbpa_rsp_if.source             rsp
);

	localparam int RAW_BLOCKS = POOL_BYTES / BLOCK_BYTES;
	localparam int MANAGED    = (RAW_BLOCKS > MAX_BLOCKS) ? MAX_BLOCKS : RAW_BLOCKS;
	localparam int BLK_W      = $clog2(BLOCK_BYTES + 1);
	localparam int PROD_W     = BLK_W + IDX_W;
	localparam logic [MAX_BLOCKS-1:0] MANAGED_MASK = (MANAGED >= MAX_BLOCKS) ? '1 :
		MAX_BLOCKS'((64'd1 << MANAGED) - 64'd1);
	localparam logic [CNT_W-1:0]  MANAGED_CNT = CNT_W'(MANAGED);
	localparam logic [ADDR_W-1:0] POOL_LIMIT  = ADDR_W'(POOL_BYTES);

	logic [ADDR_W-1:0]     pool_base_q;
	logic [MAX_BLOCKS-1:0] free_map_q;
	logic [CNT_W-1:0]      used_q;
	logic [ADDR_W-1:0]     offset_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  res_valid_q;
	status_t               res_status_q;
	logic [ADDR_W-1:0]     res_addr_q;
	logic [CNT_W-1:0]      res_used_q;

	logic [MAX_BLOCKS-1:0] free_avail;
	logic [IDX_W-1:0]      lowest_idx;
	logic                  any_free;
	logic [ADDR_W-1:0]     load_offset;
	logic [CNT_W-1:0]      blk_idx;
	logic [PROD_W-1:0]     blk_offset;
	logic [ADDR_W-1:0]     grant_addr;
	logic [CNT_W-1:0]      used_next;

	// Lowest free block among the managed ones.
	always_comb begin
		free_avail = free_map_q & MANAGED_MASK;
		any_free   = |free_avail;
		lowest_idx = '0;
		for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
			if (free_avail[i]) begin
				lowest_idx = IDX_W'(i);
			end
		end
	end

	// Block index of the request offset: the number of block boundaries at or below it,
	// found by comparing against every boundary at once and capped at the block limit.
	always_comb begin
		blk_idx = '0;
		for (int j = 1; j <= MAX_BLOCKS; j++) begin
			if (offset_q >= ADDR_W'(j * BLOCK_BYTES)) begin
				blk_idx = CNT_W'(j);
			end
		end
	end

	// Address math: request offset and granted block address.
	assign load_offset = req_free_address - pool_base_q;
	assign blk_offset  = PROD_W'(cnt_q[IDX_W-1:0]) * PROD_W'(BLOCK_BYTES);
	assign grant_addr  = pool_base_q + ADDR_W'(blk_offset);

	// Use count after the current command.
	always_comb begin
		used_next = used_q;
		if (cmd.take_bit) begin
			used_next = used_q + CNT_W'(1);
		end else if (cmd.give_bit && (used_q != '0)) begin
			used_next = used_q - CNT_W'(1);
		end
	end

	// Status toward the controller.
	always_comb begin
		stat.full         = (used_q >= MANAGED_CNT) || !any_free;
		stat.in_range     = offset_q < POOL_LIMIT;
		stat.past_managed = cnt_q >= MANAGED_CNT;
		stat.bit_free     = free_map_q[cnt_q[IDX_W-1:0]];
		stat.res_busy     = res_valid_q && !rsp.ready;
	end

	// Configuration, free map, use count and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
			free_map_q  <= '1;
			used_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pool_base_q <= cfg_wdata;
			end
			if (cmd.take_bit) begin
				free_map_q[lowest_idx] <= 1'b0;
			end else if (cmd.give_bit) begin
				free_map_q[cnt_q[IDX_W-1:0]] <= 1'b1;
			end
			used_q <= used_next;
			if (cmd.post) begin
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the request and the result payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			offset_q <= load_offset;
			cnt_q    <= '0;
		end else if (cmd.take_bit) begin
			cnt_q <= CNT_W'(lowest_idx);
		end else if (cmd.load_idx) begin
			cnt_q <= blk_idx;
		end
		if (cmd.post) begin
			res_status_q <= cmd.post_status;
			res_addr_q   <= cmd.post_addr ? grant_addr : '0;
			res_used_q   <= used_next;
		end
	end

	assign rsp.valid         = res_valid_q;
	assign rsp.status        = res_status_q;
	assign rsp.block_address = res_addr_q;
	assign rsp.blocks_in_use = res_used_q;

	// The use count always matches the number of cleared managed bits.
	a_count_matches_map: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(used_q) + 32'($countones(free_map_q & MANAGED_MASK))) == 32'(MANAGED))
		else $error("use count disagrees with free map");

	// Bits beyond the managed blocks are never cleared.
	a_unmanaged_free: assert property (@(posedge clk) disable iff (!arst_n)
		(free_map_q | MANAGED_MASK) == '1)
		else $error("unmanaged block marked in use");

	// A new result never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.post |-> (!res_valid_q || rsp.ready))
		else $error("result register overwritten");

	// A grant only happens when a free managed block exists.
	a_take_has_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_bit |-> (any_free && (used_q < MANAGED_CNT)))
		else $error("grant with no free block");

endmodule

`default_nettype wire

[sv/fbpa_controller.sv]
// Controller state machine of the allocator: sequences allocate and free requests.
`default_nettype none

module fbpa_controller import fbpa_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	fbpa_req_if.sink        req,
	input  wire fbpa_stat_t stat,
	output fbpa_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_ADDR,
		S_FREE_CHK,
		S_FREE_APPLY
	} state_t;

	state_t state_q;
	logic   accept;

	assign req.ready = (state_q == S_IDLE) && !stat.res_busy;
	assign accept    = req.valid && req.ready;

	// Commands for the datapath in each state.
	always_comb begin
		cmd             = '0;
		cmd.post_status = ST_OK;
		case (state_q)
			S_IDLE: begin
				cmd.load = accept;
			end
			S_ALLOC: begin
				if (stat.full) begin
					cmd.post        = 1'b1;
					cmd.post_status = ST_FULL;
				end else begin
					cmd.take_bit = 1'b1;
				end
			end
			S_ADDR: begin
				cmd.post      = 1'b1;
				cmd.post_addr = 1'b1;
			end
			S_FREE_CHK: begin
				if (!stat.in_range) begin
					cmd.post        = 1'b1;
					cmd.post_status = ST_OUTSIDE;
				end else begin
					cmd.load_idx = 1'b1;
				end
			end
			S_FREE_APPLY: begin
				if (stat.past_managed) begin
					cmd.post        = 1'b1;
					cmd.post_status = ST_OUTSIDE;
				end else if (stat.bit_free) begin
					cmd.post        = 1'b1;
					cmd.post_status = ST_ALREADY_FREE;
				end else begin
					cmd.give_bit = 1'b1;
					cmd.post     = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= req.mode ? S_FREE_CHK : S_ALLOC;
					end
				end
				S_ALLOC: begin
					state_q <= stat.full ? S_IDLE : S_ADDR;
				end
				S_ADDR: begin
					state_q <= S_IDLE;
				end
				S_FREE_CHK: begin
					state_q <= stat.in_range ? S_FREE_APPLY : S_IDLE;
				end
				S_FREE_APPLY: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[sv/fixed_block_pool_allocator_core.sv]
// Top level of the fixed block pool allocator.
// Allocate: S_ALLOC takes the lowest free block, S_ADDR posts its address (a full pool
// is posted from S_ALLOC). Free: S_FREE_CHK checks the range and loads the index, then
// S_FREE_APPLY updates the bit (an address outside the pool is posted from S_FREE_CHK).
// One request is in flight at a time; the next beat can be taken as the result beat leaves.
// Reset (arst_n low, asynchronous) marks every block free, zeroes the count and pool base.
`default_nettype none

module fixed_block_pool_allocator_core import fbpa_pkg::*; #(
	parameter int POOL_BYTES  = 1024,
	parameter int BLOCK_BYTES = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [ADDR_W-1:0] cfg_wdata,
	fbpa_req_if.sink               req,
	fbpa_rsp_if.source             rsp
);

	fbpa_cmd_t  cmd;
	fbpa_stat_t stat;

	// Request sequencing.
	fbpa_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Free map, count and result register.
	fbpa_datapath #(
		.POOL_BYTES  (POOL_BYTES),
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.req_free_address (req.free_address),
		.cmd              (cmd),
		.stat             (stat),
		.rsp              (rsp)
	);

endmodule

`default_nettype wire
